>>> rtl/sfsr_pkg.sv
package sfsr_pkg;

  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_SET_SPEED  = 3'd1;
  localparam logic [2:0] KIND_SET_TARGET = 3'd2;
  localparam logic [2:0] KIND_SET_ANGLE  = 3'd3;
  localparam logic [2:0] KIND_SET_LIMIT  = 3'd4;

  localparam int DIV_NW     = 22;
  localparam int DIV_DW     = 16;
  localparam int STEP_CNT_W = $clog2(DIV_NW);

  localparam int RPM_LOW   = 30;
  localparam int RPM_HIGH  = 300;
  localparam int DUTY_SPAN = 85;
  localparam int DUTY_DEN  = RPM_HIGH - RPM_LOW;
  localparam int ANGLE_DEN = 400;

  localparam int DUTY_RSH    = 29;
  localparam int DUTY_RECIP  = ((1 << DUTY_RSH) + DUTY_DEN - 1) / DUTY_DEN;
  localparam int ANGLE_RSH   = 26;
  localparam int ANGLE_RECIP = ((1 << ANGLE_RSH) + ANGLE_DEN - 1) / ANGLE_DEN;

  localparam logic [DIV_NW-1:0] PERIOD_NUM   = DIV_NW'(150000);
  localparam logic [19:0]       PERIOD_IDLE  = 20'd1000000;
  localparam logic [19:0]       PERIOD_RESET = 20'd1000;
  localparam logic [7:0]        DUTY_BASE    = 8'd150;
  localparam logic [16:0]       ANGLE_MOD    = 17'(ANGLE_DEN);
  localparam logic [2:0]        RAMP_LAST    = 3'd5;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] rpm;
    logic [15:0]        new_angle;
    logic signed [15:0] step_count;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         coils;
    logic [7:0]         duty;
    logic [19:0]        period_us;
    logic signed [15:0] cur_speed;
    logic [15:0]        cur_angle;
    logic signed [15:0] steps_left;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
  } ctl_sts_t;

  function automatic logic [3:0] phase_coils(input logic [1:0] ph);
    logic [3:0] c;
    case (ph)
      2'd0:    c = 4'd5;
      2'd1:    c = 4'd6;
      2'd2:    c = 4'd10;
      2'd3:    c = 4'd9;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/sfsr_div_lane.sv
module sfsr_div_lane #(
  parameter int NW = sfsr_pkg::DIV_NW,
  parameter int DW = sfsr_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          load,
  input  logic          step,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [NW-1:0] acc;
  logic [DW-1:0] part;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  always_comb begin
    trial = {part, acc[NW-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc   <= num;
      part  <= '0;
      den_r <= den;
    end else if (step) begin
      acc  <= {acc[NW-2:0], fits};
      part <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quo = acc;
  assign rem = part;

endmodule

>>> rtl/sfsr_datapath.sv
module sfsr_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sfsr_pkg::cmd_t      cmd_data,
  input  sfsr_pkg::ctl_cmd_t  ctl,
  output sfsr_pkg::ctl_sts_t  sts,
  output sfsr_pkg::res_t      res_data
);
  import sfsr_pkg::*;

  cmd_t               item;
  logic signed [15:0] speed_now;
  logic signed [15:0] speed_goal;
  logic signed [15:0] limit_left;
  logic [15:0]        angle_count;
  logic [1:0]         phase;
  logic [2:0]         ramp_count;
  logic [3:0]         coil_bits;
  logic [7:0]         duty_reg;
  logic [19:0]        period_reg;
  logic [STEP_CNT_W-1:0] step_cnt;
  res_t               res;

  logic signed [15:0] speed_next;
  logic signed [15:0] goal_next;
  logic signed [15:0] limit_next;
  logic [15:0]        angle_next;
  logic [1:0]         phase_next;
  logic [2:0]         ramp_next;
  logic [3:0]         coils_next;
  logic [7:0]         duty_next;
  logic [19:0]        period_next;

  logic               do_apply;
  logic               tick_coils;
  logic signed [15:0] apply_rpm;

  logic signed [16:0] duty_off;
  logic signed [23:0] duty_prod;
  logic [23:0]        duty_mag;
  logic [DIV_NW-1:0]  duty_mag_r;
  logic               duty_neg;
  logic [42:0]        duty_scaled;
  logic [7:0]         duty_quo;
  logic [7:0]         duty_q8;
  logic [7:0]         duty_calc;

  logic [16:0]        ang_num;
  logic [34:0]        ang_scaled;
  logic [7:0]         ang_quo;
  logic [16:0]        ang_back;
  logic [16:0]        ang_diff;

  logic [DIV_NW-1:0]  per_num;
  logic [DIV_DW-1:0]  per_den;
  logic [DIV_NW-1:0]  per_quo;
  logic [DIV_DW-1:0]  per_rem;

  always_comb begin
    goal_next   = speed_goal;
    limit_next  = limit_left;
    angle_next  = angle_count;
    phase_next  = phase;
    ramp_next   = ramp_count;
    do_apply    = 1'b0;
    tick_coils  = 1'b0;
    apply_rpm   = speed_now;
    case (item.kind)
      KIND_TICK: begin
        if (speed_now != 16'sd0) begin
          angle_next = ang_diff[15:0];
          if (limit_left == 16'sd0) begin
            if (speed_now > 16'sd0) begin
              do_apply  = 1'b1;
              apply_rpm = 16'sd0;
            end
          end else begin
            if (limit_left > 16'sd0) begin
              limit_next = limit_left - 16'sd1;
            end
            if (speed_goal != speed_now) begin
              if (ramp_count > RAMP_LAST) begin
                do_apply  = 1'b1;
                apply_rpm = (speed_goal > speed_now) ? speed_now + 16'sd1
                                                     : speed_now - 16'sd1;
                ramp_next = 3'd0;
              end else begin
                ramp_next = ramp_count + 3'd1;
              end
            end
            phase_next = phase + 2'd1;
            tick_coils = 1'b1;
          end
        end
      end
      KIND_SET_SPEED: begin
        goal_next = item.rpm;
        do_apply  = 1'b1;
        apply_rpm = item.rpm;
      end
      KIND_SET_TARGET: begin
        goal_next = item.rpm;
      end
      KIND_SET_ANGLE: begin
        angle_next = item.new_angle;
      end
      KIND_SET_LIMIT: begin
        limit_next = item.step_count;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    duty_off    = {apply_rpm[15], apply_rpm} - 17'(RPM_LOW);
    duty_prod   = 24'(duty_off) * 24'(DUTY_SPAN);
    duty_mag    = duty_prod[23] ? 24'(-duty_prod) : 24'(duty_prod);
    duty_scaled = 43'(duty_mag_r) * 43'(DUTY_RECIP);
    duty_q8     = duty_neg ? 8'(-duty_quo) : duty_quo;
    duty_calc   = DUTY_BASE + duty_q8;
    per_num     = PERIOD_NUM;
    per_den     = (apply_rpm > 16'sd0) ? DIV_DW'(apply_rpm) : DIV_DW'(1);
    ang_num     = {1'b0, angle_count} + 17'd1;
    ang_scaled  = 35'(ang_num) * 35'(ANGLE_RECIP);
    ang_back    = {9'd0, ang_quo} * ANGLE_MOD;
    ang_diff    = ang_num - ang_back;
  end

  always_comb begin
    speed_next  = speed_now;
    coils_next  = coil_bits;
    duty_next   = duty_reg;
    period_next = period_reg;
    if (do_apply) begin
      speed_next  = apply_rpm;
      period_next = (apply_rpm > 16'sd0) ? per_quo[19:0] : PERIOD_IDLE;
      if (apply_rpm == 16'sd0) begin
        duty_next  = 8'd0;
        coils_next = 4'd0;
      end else begin
        duty_next = duty_calc;
      end
    end
    if (tick_coils) begin
      coils_next = phase_coils(phase_next);
    end
  end

  sfsr_div_lane #(.NW(DIV_NW), .DW(DIV_DW)) u_per_div (
    .clk  (clk),
    .load (ctl.load),
    .step (ctl.step),
    .num  (per_num),
    .den  (per_den),
    .quo  (per_quo),
    .rem  (per_rem)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= cmd_data;
    end
    if (ctl.load) begin
      duty_mag_r <= duty_mag[DIV_NW-1:0];
      duty_neg   <= duty_prod[23];
    end
    if (ctl.step) begin
      duty_quo <= duty_scaled[DUTY_RSH +: 8];
      ang_quo  <= ang_scaled[ANGLE_RSH +: 8];
    end
    if (ctl.commit) begin
      res.coils      <= coils_next;
      res.duty       <= duty_next;
      res.period_us  <= period_next;
      res.cur_speed  <= speed_next;
      res.cur_angle  <= angle_next;
      res.steps_left <= limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now   <= 16'sd0;
      speed_goal  <= 16'sd0;
      limit_left  <= -16'sd1;
      angle_count <= 16'd0;
      phase       <= 2'd0;
      ramp_count  <= 3'd0;
      coil_bits   <= 4'd0;
      duty_reg    <= 8'd0;
      period_reg  <= PERIOD_RESET;
      step_cnt    <= '0;
    end else begin
      if (ctl.load) begin
        step_cnt <= '0;
      end else if (ctl.step) begin
        step_cnt <= step_cnt + STEP_CNT_W'(1);
      end
      if (ctl.commit) begin
        speed_now   <= speed_next;
        speed_goal  <= goal_next;
        limit_left  <= limit_next;
        angle_count <= angle_next;
        phase       <= phase_next;
        ramp_count  <= ramp_next;
        coil_bits   <= coils_next;
        duty_reg    <= duty_next;
        period_reg  <= period_next;
      end
    end
  end

  assign sts.div_last = (step_cnt == STEP_CNT_W'(DIV_NW - 1));
  assign res_data     = res;

  a_load_clears_count: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> step_cnt == '0)
    else $error("step count not cleared by load");

  a_idle_tick_holds_speed: assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && item.kind == KIND_TICK && speed_now == 16'sd0) |=> $stable(speed_now))
    else $error("tick at rest changed speed");

  a_tick_angle_wraps: assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && item.kind == KIND_TICK && speed_now != 16'sd0)
      |=> angle_count < 16'd400)
    else $error("angle out of range after step");

endmodule

>>> rtl/sfsr_ctrl.sv
module sfsr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output logic                res_valid,
  input  logic                res_stall,
  input  sfsr_pkg::ctl_sts_t  sts,
  output sfsr_pkg::ctl_cmd_t  ctl
);
  import sfsr_pkg::*;

  state_t state;
  state_t state_next;
  logic   res_free;

  assign res_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (cmd_valid) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (sts.div_last) state_next = ST_COMMIT;
      ST_COMMIT: if (res_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    cmd_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        cmd_stall   = 1'b0;
        ctl.capture = cmd_valid;
      end
      ST_LOAD:   ctl.load = 1'b1;
      ST_DIVIDE: ctl.step = 1'b1;
      ST_COMMIT: ctl.commit = res_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= ctl.commit || (res_valid && res_stall);
    end
  end

  a_accept_starts_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && cmd_valid) |=> state == ST_LOAD)
    else $error("accepted beat did not start a load");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> res_valid)
    else $error("commit without result beat");

  a_divide_runs_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && !sts.div_last) |=> state == ST_DIVIDE)
    else $error("divide left early");

endmodule

>>> rtl/stepper_full_step_ramp_driver.sv
// Channel   Valid       Stall       Payload
// command   cmd_valid   cmd_stall   cmd_data (kind, rpm, new_angle, step_count)
// result    res_valid   res_stall   res_data (coils, duty, period_us, cur_speed,
//                                              cur_angle, steps_left)
//
// A command is taken only once the previous one is through: the accept cycle, an operand load,
// the restoring period divider (duty and angle wrap products settle meanwhile) and a commit.
// The next command is taken once the prior result is latched, even while
// that beat is stalled; a stalled result beat holds commit and with it the command channel.
// Synchronous reset zeroes speed, target, angle, phase, ramp count, coils and duty, sets the
// step limit to unlimited and the period to 1000 us.
module stepper_full_step_ramp_driver (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  sfsr_pkg::cmd_t  cmd_data,
  output logic            res_valid,
  input  logic            res_stall,
  output sfsr_pkg::res_t  res_data
);
  import sfsr_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  sfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  sfsr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd_data (cmd_data),
    .ctl      (ctl),
    .sts      (sts),
    .res_data (res_data)
  );

endmodule

>>> tb/stepper_full_step_ramp_driver_test.sv
module stepper_full_step_ramp_driver_test;
  import sfsr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 60;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  localparam int SPEED_NUM   = 150000;
  localparam int IDLE_PERIOD = 1000000;
  localparam int DUTY_MID    = 150;
  localparam int SPEED_LO    = 30;
  localparam int SPEED_HI    = 300;
  localparam int SLOPE       = 85;
  localparam int ANGLE_WRAP  = 400;
  localparam int RAMP_FIRE   = 5;
  localparam logic [15:0] COIL_SEQ = {4'd9, 4'd10, 4'd6, 4'd5};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int errors = 0;
  res_t states_due[$];
  res_t want;

  int         speed_now = 0;
  int         speed_goal = 0;
  int         limit_left = -1;
  int         angle_count = 0;
  logic [1:0] phase = 2'd0;
  logic [2:0] ramp_count = 3'd0;
  logic [3:0] coil_bits = 4'd0;
  logic [7:0] duty_reg = 8'd0;
  logic [19:0] period_reg = 20'd1000;

  stepper_full_step_ramp_driver u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data(cmd_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void load_speed(input int r);
    int m;
    if (r > 0) begin
      period_reg = 20'(SPEED_NUM / r);
    end else begin
      period_reg = 20'(IDLE_PERIOD);
    end
    m = ((r - SPEED_LO) * SLOPE) / (SPEED_HI - SPEED_LO);
    duty_reg = 8'(DUTY_MID + m);
    if (r == 0) begin
      duty_reg = 8'd0;
      coil_bits = 4'd0;
    end
    speed_now = r;
  endfunction

  function automatic void step_motor();
    logic [2:0] old_ramp;
    if (speed_now == 0) return;
    angle_count = (angle_count + 1) % ANGLE_WRAP;
    if (limit_left == 0) begin
      if (speed_now > 0) load_speed(0);
      return;
    end else if (limit_left > 0) begin
      limit_left = limit_left - 1;
    end
    if (speed_goal != speed_now) begin
      old_ramp = ramp_count;
      ramp_count = ramp_count + 3'd1;
      if (old_ramp > RAMP_FIRE) begin
        load_speed(speed_goal > speed_now ? speed_now + 1 : speed_now - 1);
        ramp_count = 3'd0;
      end
    end
    phase = phase + 2'd1;
    coil_bits = COIL_SEQ[phase*4 +: 4];
  endfunction

  function automatic res_t driver_state_after(input cmd_t c);
    res_t r;
    case (c.kind)
      KIND_TICK: step_motor();
      KIND_SET_SPEED: begin
        speed_goal = $signed(c.rpm);
        load_speed(speed_goal);
      end
      KIND_SET_TARGET: speed_goal = $signed(c.rpm);
      KIND_SET_ANGLE:  angle_count = int'(c.new_angle);
      KIND_SET_LIMIT:  limit_left = $signed(c.step_count);
      default: ;
    endcase
    r.coils      = coil_bits;
    r.duty       = duty_reg;
    r.period_us  = period_reg;
    r.cur_speed  = 16'(speed_now);
    r.cur_angle  = 16'(angle_count);
    r.steps_left = 16'(limit_left);
    return r;
  endfunction

  function automatic cmd_t command_of(input logic [2:0] k, input int v);
    cmd_t c;
    c.kind       = k;
    c.rpm        = 16'($urandom);
    c.new_angle  = 16'($urandom);
    c.step_count = 16'($urandom);
    case (k)
      KIND_SET_SPEED, KIND_SET_TARGET: c.rpm = 16'(v);
      KIND_SET_ANGLE: c.new_angle = 16'(v);
      KIND_SET_LIMIT: c.step_count = 16'(v);
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    if ($urandom_range(99) < snd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    states_due.push_back(driver_state_after(c));
  endtask

  task automatic send_kind(input logic [2:0] k, input int v);
    send_cmd(command_of(k, v));
  endtask

  task automatic wait_results_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (states_due.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [19:0] exp_v,
                               input logic [19:0] got_v);
    $display("%0t %s expected %0h actual %0h", $time, field, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (states_due.size() == 0) begin
          $display("%0t unexpected beat expected none actual %h", $time, res_data);
          errors++;
        end else begin
          want = states_due.pop_front();
          if (res_data.coils !== want.coils)
            note_mismatch("coils", want.coils, res_data.coils);
          if (res_data.duty !== want.duty)
            note_mismatch("duty", want.duty, res_data.duty);
          if (res_data.period_us !== want.period_us)
            note_mismatch("period_us", want.period_us, res_data.period_us);
          if (res_data.cur_speed !== want.cur_speed)
            note_mismatch("cur_speed", want.cur_speed, res_data.cur_speed);
          if (res_data.cur_angle !== want.cur_angle)
            note_mismatch("cur_angle", want.cur_angle, res_data.cur_angle);
          if (res_data.steps_left !== want.steps_left)
            note_mismatch("steps_left", want.steps_left, res_data.steps_left);
        end
      end
      res_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  task automatic test_idle_and_unused();
    send_kind(KIND_TICK, 0);
    send_kind(KIND_UNUSED_FIRST, 0);
    send_kind(KIND_UNUSED_LAST, 0);
  endtask

  task automatic test_speed_extremes();
    send_kind(KIND_SET_SPEED, 32767);
    send_kind(KIND_SET_SPEED, -32768);
    send_kind(KIND_SET_SPEED, 29);
    send_kind(KIND_SET_SPEED, -1);
  endtask

  task automatic test_angle_wrap();
    send_kind(KIND_SET_ANGLE, 65535);
    send_kind(KIND_TICK, 0);
    send_kind(KIND_SET_ANGLE, 399);
    send_kind(KIND_TICK, 0);
  endtask

  task automatic test_step_limit();
    send_kind(KIND_SET_SPEED, 50);
    send_kind(KIND_SET_LIMIT, 1);
    send_kind(KIND_TICK, 0);
    send_kind(KIND_TICK, 0);
    send_kind(KIND_SET_SPEED, -3);
    send_kind(KIND_TICK, 0);
    send_kind(KIND_SET_LIMIT, -2);
    send_kind(KIND_TICK, 0);
  endtask

  task automatic test_ramp_through_zero();
    send_kind(KIND_SET_SPEED, 1);
    send_kind(KIND_SET_TARGET, -1);
    repeat (7) send_kind(KIND_TICK, 0);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    int sub;
    repeat (count) begin
      pick = $urandom_range(99);
      sub  = $urandom_range(99);
      if (pick < 58) begin
        send_kind(KIND_TICK, 0);
      end else if (pick < 68) begin
        send_kind(KIND_SET_TARGET, speed_now + $urandom_range(40) - 20);
      end else if (pick < 76) begin
        if (sub < 70) send_kind(KIND_SET_SPEED, $urandom_range(600) - 300);
        else send_kind(KIND_SET_SPEED, $urandom);
      end else if (pick < 84) begin
        if (sub < 50) send_kind(KIND_SET_LIMIT, $urandom_range(30));
        else if (sub < 70) send_kind(KIND_SET_LIMIT, -1);
        else send_kind(KIND_SET_LIMIT, $urandom);
      end else if (pick < 90) begin
        if (sub < 70) send_kind(KIND_SET_ANGLE, $urandom_range(ANGLE_WRAP - 1));
        else send_kind(KIND_SET_ANGLE, $urandom);
      end else if (pick < 95) begin
        send_kind(KIND_SET_TARGET, $urandom);
      end else begin
        send_kind(3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST)), 0);
      end
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 28;
    rcv_idle_pct = 46;
    test_idle_and_unused();
    test_speed_extremes();
    test_angle_wrap();
    test_step_limit();
    test_ramp_through_zero();
    test_random_traffic(100);
    wait_results_drained();
    test_random_traffic(100);
    wait_results_drained();

    snd_idle_pct = 46;
    rcv_idle_pct = 28;
    test_random_traffic(200);
    wait_results_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(200);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
